// ===== design/bli_pkg.sv =====
// Shared types, constants and codes for the bounded list block.
package bli_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CNTO_W   = 5;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned WORD_W   = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ERASE      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] value_in;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value_out;
    logic [STAT_W-1:0]        status;
    logic [CNTO_W-1:0]        count_out;
  } rsp_t;

endpackage

// ===== design/bli_in_reg.sv =====
// Input request register with valid/stall handshake.
module bli_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bli_pkg::req_t in_req_i,
  output logic          req_valid_o,
  output bli_pkg::req_t req_o,
  input  logic          req_take_i
);

  logic          valid_q, valid_d;
  bli_pkg::req_t req_q;
  logic          load;

  assign in_stall_o = valid_q && !req_take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (req_take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= in_req_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// ===== design/bli_list.sv =====
// Entry array and count, with a neighbor shift of the entry registers for insert and erase.
module bli_list (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          exec_i,
  input  bli_pkg::req_t req_i,
  output bli_pkg::rsp_t rsp_o
);

  logic [bli_pkg::WORD_W-1:0] entries_q [bli_pkg::CAPACITY];
  logic [bli_pkg::WORD_W-1:0] entries_d [bli_pkg::CAPACITY];
  logic [bli_pkg::CNT_W-1:0]  count_q, count_d;

  logic                        full, empty, pos_in_range, pos_zero;
  logic                        do_place, do_take;
  logic [bli_pkg::IDX_W-1:0]   place_idx, take_idx, pos_idx, last_idx;
  logic [bli_pkg::STAT_W-1:0]  status;
  logic [bli_pkg::WORD_W-1:0]  removed;

  assign full         = (count_q == bli_pkg::CNT_W'(bli_pkg::CAPACITY));
  assign empty        = (count_q == '0);
  assign pos_zero     = (req_i.position == '0);
  assign pos_in_range = (bli_pkg::CMP_W'(req_i.position) < bli_pkg::CMP_W'(count_q));
  assign pos_idx      = bli_pkg::IDX_W'(req_i.position);
  assign last_idx     = bli_pkg::IDX_W'(count_q - 1'b1);

  always_comb begin
    do_place  = 1'b0;
    do_take   = 1'b0;
    place_idx = '0;
    take_idx  = '0;
    status    = bli_pkg::ST_OK;
    unique case (req_i.action)
      bli_pkg::ACT_PUSH_BACK: begin
        if (full) status = bli_pkg::ST_FULL;
        else begin
          do_place  = 1'b1;
          place_idx = bli_pkg::IDX_W'(count_q);
        end
      end
      bli_pkg::ACT_POP_BACK: begin
        if (empty) status = bli_pkg::ST_EMPTY;
        else begin
          do_take  = 1'b1;
          take_idx = last_idx;
        end
      end
      bli_pkg::ACT_PUSH_FRONT: begin
        if (full) status = bli_pkg::ST_FULL;
        else do_place = 1'b1;
      end
      bli_pkg::ACT_POP_FRONT: begin
        if (empty) status = bli_pkg::ST_EMPTY;
        else do_take = 1'b1;
      end
      bli_pkg::ACT_INSERT: begin
        if (empty) do_place = 1'b1;
        else if (!pos_zero && !pos_in_range) status = bli_pkg::ST_RANGE;
        else if (full) status = bli_pkg::ST_FULL;
        else begin
          do_place  = 1'b1;
          place_idx = pos_idx;
        end
      end
      bli_pkg::ACT_ERASE: begin
        if (empty) status = bli_pkg::ST_EMPTY;
        else if (!pos_in_range) status = bli_pkg::ST_RANGE;
        else begin
          do_take  = 1'b1;
          take_idx = pos_idx;
        end
      end
      default: ;
    endcase
  end

  assign removed = do_take ? entries_q[take_idx] : '0;

  always_comb begin
    for (int unsigned i = 0; i < bli_pkg::CAPACITY; i++) begin
      entries_d[i] = entries_q[i];
      if (do_place) begin
        if (bli_pkg::IDX_W'(i) == place_idx) begin
          entries_d[i] = req_i.value_in;
        end else if (bli_pkg::IDX_W'(i) > place_idx && i > 0) begin
          entries_d[i] = entries_q[i-1];
        end
      end else if (do_take) begin
        if (bli_pkg::IDX_W'(i) >= take_idx && i + 1 < bli_pkg::CAPACITY) begin
          entries_d[i] = entries_q[i+1];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (req_i.action == bli_pkg::ACT_CLEAR) count_d = '0;
    else if (do_place) count_d = count_q + 1'b1;
    else if (do_take) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (exec_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_i) begin
      entries_q <= entries_d;
    end
  end

  assign rsp_o.value_out = removed;
  assign rsp_o.status    = status;
  assign rsp_o.count_out = bli_pkg::CNTO_W'(count_d);

endmodule

// ===== design/bli_out_reg.sv =====
// Result register with valid/stall handshake.
module bli_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  bli_pkg::rsp_t rsp_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bli_pkg::rsp_t rsp_o
);

  logic          valid_q, valid_d;
  bli_pkg::rsp_t rsp_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (free_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== design/bounded_list_insert_erase.sv =====
// Top level of the bounded ordered list with insert and erase.
// A request passes through the input register, then the result register; a stalled output holds it in the input reg.
// Throughput: one request per cycle while the output is not stalled; the list update is a neighbor
// shift in the entry register array.
// Reset: count cleared, both stages empty; entry contents are not reset.
module bounded_list_insert_erase (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bli_pkg::ACT_W-1:0]           action_i,
  input  logic signed [bli_pkg::WORD_W-1:0]   value_in_i,
  input  logic [bli_pkg::POS_W-1:0]           position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bli_pkg::WORD_W-1:0]   value_out_o,
  output logic [bli_pkg::STAT_W-1:0]          status_o,
  output logic [bli_pkg::CNTO_W-1:0]          count_out_o
);

  bli_pkg::req_t in_req, req;
  bli_pkg::rsp_t rsp, rsp_reg;
  logic          req_valid, out_free, exec;

  assign in_req.action   = action_i;
  assign in_req.value_in = value_in_i;
  assign in_req.position = position_i;

  assign exec = req_valid && out_free;

  bli_in_reg u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_take_i  (exec)
  );

  bli_list u_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  bli_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (exec),
    .rsp_i       (rsp),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rsp_o       (rsp_reg)
  );

  assign value_out_o = rsp_reg.value_out;
  assign status_o    = rsp_reg.status;
  assign count_out_o = rsp_reg.count_out;

endmodule

// ===== verif/bli_checker.sv =====
// Checker for the bounded list: watches both channels, predicts each result and compares it.
module bli_checker
  import bli_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic                      req_stall_i,
  input  logic [ACT_W-1:0]          action_i,
  input  logic signed [WORD_W-1:0]  value_in_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic                      rsp_valid_i,
  input  logic                      rsp_stall_i,
  input  logic signed [WORD_W-1:0]  value_out_i,
  input  logic [STAT_W-1:0]         status_i,
  input  logic [CNTO_W-1:0]         count_out_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [WORD_W-1:0] shadow_list [CAPACITY];
  int unsigned              shadow_count;
  rsp_t                     expected_q [$];
  rsp_t                     want;
  int unsigned              mismatches = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t checker: %s got %0h expected %0h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  function automatic void place_word(input int unsigned pos, input logic signed [WORD_W-1:0] w);
    int unsigned i;
    for (i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[pos] = w;
    shadow_count++;
  endfunction

  function automatic logic signed [WORD_W-1:0] take_word(input int unsigned pos);
    logic signed [WORD_W-1:0] w;
    int unsigned i;
    w = shadow_list[pos];
    for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
    return w;
  endfunction

  function automatic rsp_t predict_list_step(input logic [ACT_W-1:0] act,
                                             input logic signed [WORD_W-1:0] w,
                                             input logic [POS_W-1:0] pos);
    rsp_t r;
    logic full;
    r = '0;
    r.status = ST_OK;
    full = (shadow_count >= CAPACITY);
    case (act)
      ACT_PUSH_BACK: begin
        if (full) r.status = ST_FULL;
        else place_word(shadow_count, w);
      end
      ACT_POP_BACK: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.value_out = take_word(shadow_count - 1);
      end
      ACT_PUSH_FRONT: begin
        if (full) r.status = ST_FULL;
        else place_word(0, w);
      end
      ACT_POP_FRONT: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.value_out = take_word(0);
      end
      ACT_INSERT: begin
        if (shadow_count == 0) place_word(0, w);
        else if (pos != 0 && pos >= shadow_count) r.status = ST_RANGE;
        else if (full) r.status = ST_FULL;
        else place_word(pos, w);
      end
      ACT_ERASE: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (pos >= shadow_count) r.status = ST_RANGE;
        else r.value_out = take_word(pos);
      end
      ACT_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.count_out = shadow_count[CNTO_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      expected_q.delete();
      pending_count_o  <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (req_valid_i && !req_stall_i)
        expected_q.insert(expected_q.size(),
                          predict_list_step(action_i, value_in_i, position_i));
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no pending request, value_out", value_out_i, '0);
        end else begin
          want = expected_q.pop_front();
          if (value_out_i !== want.value_out)
            report_mismatch("value_out", value_out_i, want.value_out);
          if (status_i !== want.status)
            report_mismatch("status", 32'(status_i), 32'(want.status));
          if (count_out_i !== want.count_out)
            report_mismatch("count_out", 32'(count_out_i), 32'(want.count_out));
        end
      end
      pending_count_o  <= expected_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the bounded list testbench: clock, reset, request stimulus and verdict.
module testbench;
  import bli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACT_W-1:0]  ACT_UNUSED = 3'd7;
  localparam logic [WORD_W-1:0] WORD_MIN   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX   = 32'h7fff_ffff;
  localparam int unsigned       PHASES     = 8;
  localparam int unsigned       PHASE_REQS = 192;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [ACT_W-1:0]         action_i    = '0;
  logic signed [WORD_W-1:0] value_in_i  = '0;
  logic [POS_W-1:0]         position_i  = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [WORD_W-1:0] value_out_o;
  logic [STAT_W-1:0]        status_o;
  logic [CNTO_W-1:0]        count_out_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  always #4ns clk_i = ~clk_i;

  bounded_list_insert_erase i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .value_in_i, .position_i,
    .out_valid_o, .out_stall_i, .value_out_o, .status_o, .count_out_o
  );

  bli_checker i_checker (
    .clk_i, .rst_ni,
    .req_valid_i      (in_valid_i),
    .req_stall_i      (in_stall_o),
    .action_i, .value_in_i, .position_i,
    .rsp_valid_i      (out_valid_o),
    .rsp_stall_i      (out_stall_i),
    .value_out_i      (value_out_o),
    .status_i         (status_o),
    .count_out_i      (count_out_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] w,
                              input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_in_i <= w;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // hold off requests until every outstanding result has returned
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  function automatic logic [ACT_W-1:0] pick_action(input int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mode)
      0: begin
        if (roll < 30) return ACT_PUSH_BACK;
        if (roll < 55) return ACT_PUSH_FRONT;
        if (roll < 85) return ACT_INSERT;
        if (roll < 90) return ACT_POP_BACK;
        if (roll < 95) return ACT_ERASE;
        if (roll < 99) return ACT_POP_FRONT;
        return ($urandom_range(1) != 0) ? ACT_CLEAR : ACT_UNUSED;
      end
      1: begin
        if (roll < 25) return ACT_POP_BACK;
        if (roll < 50) return ACT_POP_FRONT;
        if (roll < 85) return ACT_ERASE;
        if (roll < 92) return ACT_PUSH_BACK;
        if (roll < 97) return ACT_INSERT;
        if (roll < 98) return ACT_PUSH_FRONT;
        if (roll < 99) return ACT_CLEAR;
        return ACT_UNUSED;
      end
      default: begin
        if (roll < 15) return ACT_PUSH_BACK;
        if (roll < 30) return ACT_POP_BACK;
        if (roll < 45) return ACT_PUSH_FRONT;
        if (roll < 60) return ACT_POP_FRONT;
        if (roll < 78) return ACT_INSERT;
        if (roll < 94) return ACT_ERASE;
        if (roll < 97) return ACT_CLEAR;
        return ACT_UNUSED;
      end
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(9) != 0) return $urandom;
    case ($urandom_range(3))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(99) < 80) return POS_W'($urandom_range(16));
    return POS_W'($urandom_range(31));
  endfunction

  initial begin
    #2ms;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned run_left;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty and nearly empty list corner cases
    send_request(ACT_POP_BACK, '0, '0);
    send_request(ACT_POP_FRONT, '0, '0);
    send_request(ACT_ERASE, '0, '0);
    send_request(ACT_INSERT, WORD_MAX, 5'd31);
    send_request(ACT_ERASE, '0, 5'd31);
    send_request(ACT_INSERT, '1, 5'd31);
    send_request(ACT_INSERT, WORD_MIN, '0);
    send_request(ACT_ERASE, '0, '0);
    send_request(ACT_UNUSED, '1, 5'd31);
    send_request(ACT_CLEAR, '0, '0);
    // fill to capacity, then hit the full list
    for (int k = 0; k < CAPACITY; k++) begin
      case (k % 3)
        0: send_request(ACT_INSERT, $urandom, POS_W'(k / 2));
        1: send_request(ACT_PUSH_BACK, WORD_MIN + k, '0);
        default: send_request(ACT_PUSH_FRONT, WORD_MAX - k, '0);
      endcase
    end
    send_request(ACT_PUSH_BACK, '1, '0);
    send_request(ACT_PUSH_FRONT, '1, '0);
    send_request(ACT_INSERT, '1, '0);
    send_request(ACT_INSERT, '1, 5'd16);
    send_request(ACT_ERASE, '0, 5'd15);
    send_request(ACT_POP_BACK, '0, '0);
    send_request(ACT_POP_FRONT, '0, '0);
    send_request(ACT_CLEAR, '0, '0);
    wait_for_results();

    mode = 0;
    run_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (run_left == 0) begin
          mode = $urandom_range(2);
          run_left = $urandom_range(10, 40);
        end
        run_left--;
        send_request(pick_action(mode), pick_word(), pick_position());
      end
      wait_for_results();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== bounded_list_insert_erase.f =====
design/bli_pkg.sv
design/bli_in_reg.sv
design/bli_list.sv
design/bli_out_reg.sv
design/bounded_list_insert_erase.sv
verif/bli_checker.sv
verif/testbench.sv
